[hdl/char_pattern_table_wide_expand_core_macros.svh]
// Assertion macros used by the character pattern table top level.
`ifndef CHAR_PATTERN_TABLE_WIDE_EXPAND_CORE_MACROS_SVH
`define CHAR_PATTERN_TABLE_WIDE_EXPAND_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on the rising clock edge outside of reset.
`define CPWE_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpwe: same-cycle check failed");
// Next-cycle implication, sampled on the rising clock edge outside of reset.
`define CPWE_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpwe: next-cycle check failed");
`else
`define CPWE_ASSERT_SAME(name, ante, cons)
`define CPWE_ASSERT_NEXT(name, ante, cons)
`endif

`endif

[hdl/cpwe_pkg.sv]
// Package with types, constants and pixel functions of the character pattern table.
package cpwe_pkg;

    // Default number of scan rows per character.
    localparam int CHAR_ROWS_DEF = 12;
    // Number of character codes held in the store.
    localparam int NUM_CODES = 256;

    // Configuration register indexes.
    localparam logic [2:0] CFG_EIGHT_PIXEL = 3'd0;
    localparam logic [2:0] CFG_GFX_LOW     = 3'd1;
    localparam logic [2:0] CFG_GFX_HIGH    = 3'd2;
    localparam logic [2:0] CFG_BLANK_UPPER = 3'd3;
    localparam logic [2:0] CFG_BLANK_LOWER = 3'd4;

    // Semigraphics cell masks.
    localparam logic [7:0] LEFT_CELL_8  = 8'hF0;
    localparam logic [7:0] LEFT_CELL_6  = 8'hE0;
    localparam logic [7:0] RIGHT_CELL_8 = 8'h0F;
    localparam logic [7:0] RIGHT_CELL_6 = 8'h1C;

    // Command codes; code 3 has no meaning and is ignored.
    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_UPDATE = 2'd1,
        CMD_READ   = 2'd2
    } cmd_t;

    // Configuration register set.
    typedef struct packed {
        logic eight_pixel;
        logic gfx_low;
        logic gfx_high;
        logic blank_upper;
        logic blank_lower;
    } cfg_t;

    // Reverses the bit order of a byte.
    function automatic logic [7:0] flip8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[7 - i] = v[i];
        end
        return r;
    endfunction

    // Left half of a row with every pixel doubled.
    function automatic logic [7:0] widen_left(input logic [7:0] r, input logic eight);
        logic [7:0] w;
        if (eight) begin
            w = {r[7], r[7], r[6], r[6], r[5], r[5], r[4], r[4]};
        end
        else begin
            w = {r[7], r[7], r[6], r[6], r[5], r[5], 2'b00};
        end
        return w;
    endfunction

    // Right half of a row with every pixel doubled.
    function automatic logic [7:0] widen_right(input logic [7:0] r, input logic eight);
        logic [7:0] w;
        if (eight) begin
            w = {r[3], r[3], r[2], r[2], r[1], r[1], r[0], r[0]};
        end
        else begin
            w = {r[4], r[4], r[3], r[3], r[2], r[2], 2'b00};
        end
        return w;
    endfunction

endpackage

[hdl/cpwe_ram.sv]
// Generic single-port synchronous RAM with registered read data.
module cpwe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 3072
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write on enable, otherwise read into the registered read data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/cpwe_fmt.sv]
// Row formatter: builds the byte written by load and update commands.
module cpwe_fmt #(
    parameter int CHAR_ROWS = cpwe_pkg::CHAR_ROWS_DEF
) (
    input  cpwe_pkg::cmd_t cmd,
    input  logic [7:0]     char_code,
    input  logic [3:0]     row_index,
    input  logic [7:0]     pixel_bits,
    input  cpwe_pkg::cfg_t cfg,
    output logic [7:0]     wr_value
);
    import cpwe_pkg::*;

    localparam int THIRD_ROWS = CHAR_ROWS / 3;

    logic [1:0] third;
    logic [1:0] cell_bits;
    logic [7:0] left_cell;
    logic [7:0] right_cell;
    logic [7:0] gfx_row;
    logic [7:0] load_row;
    logic       gfx_on;

    // Which third of the character cell the row falls in.
    always_comb
    begin
        if (row_index >= 4'(2 * THIRD_ROWS))
        begin
            third = 2'd2;
        end
        else if (row_index >= 4'(THIRD_ROWS))
        begin
            third = 2'd1;
        end
        else
        begin
            third = 2'd0;
        end
    end

    // Pick the two code bits that light the cells of this third.
    always_comb
    begin
        case (third)
            2'd0:    cell_bits = char_code[1:0];
            2'd1:    cell_bits = char_code[3:2];
            2'd2:    cell_bits = char_code[5:4];
            default: cell_bits = 2'b00;
        endcase
    end

    // Semigraphics row from the cell masks of the current pixel mode.
    assign left_cell  = cfg.eight_pixel ? LEFT_CELL_8 : LEFT_CELL_6;
    assign right_cell = cfg.eight_pixel ? RIGHT_CELL_8 : RIGHT_CELL_6;
    assign gfx_row    = (cell_bits[0] ? left_cell : 8'h00) | (cell_bits[1] ? right_cell : 8'h00);
    assign gfx_on     = char_code[6] ? cfg.gfx_high : cfg.gfx_low;

    // Load value: blanking of the upper half wins over semigraphics.
    always_comb
    begin
        if (char_code[7])
        begin
            if (cfg.blank_upper)
            begin
                load_row = 8'h00;
            end
            else if (gfx_on)
            begin
                load_row = gfx_row;
            end
            else
            begin
                load_row = flip8(pixel_bits);
            end
        end
        else
        begin
            load_row = cfg.blank_lower ? 8'h00 : flip8(pixel_bits);
        end
    end

    // Update stores the bits directly, moved to the top in 6-pixel mode.
    always_comb
    begin
        case (cmd)
            CMD_LOAD:   wr_value = load_row;
            CMD_UPDATE: wr_value = cfg.eight_pixel ? pixel_bits : {pixel_bits[5:0], 2'b00};
            default:    wr_value = 8'h00;
        endcase
    end

endmodule

[hdl/char_pattern_table_wide_expand_core.sv]
// Top level of the character pattern table with semigraphics and double-width rows.
//
// Channel   Direction  Transfer condition      Payload
// command   in         start && !busy          command, char_code, row_index, pixel_bits
// result    out        done (one cycle)        accepted, normal_row, wide_left_row, wide_right_row
// config    in         cfg_write               cfg_index, cfg_data
//
// A command is taken every cycle; busy stays low. Each result passes the input register
// and then the result registers, which line up with the registered read port of the
// pattern RAM. A write lands before any later read is issued, so no forwarding is
// needed. Reset clears the control state and sets the configuration to its defaults;
// the pattern RAM is not cleared. The receiver cannot stall, so nothing is held back.
`include "char_pattern_table_wide_expand_core_macros.svh"

module char_pattern_table_wide_expand_core #(
    parameter int CHAR_ROWS = cpwe_pkg::CHAR_ROWS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] command,
    input  logic [7:0] char_code,
    input  logic [3:0] row_index,
    input  logic [7:0] pixel_bits,
    output logic       done,
    output logic       accepted,
    output logic [7:0] normal_row,
    output logic [7:0] wide_left_row,
    output logic [7:0] wide_right_row,
    input  logic       cfg_write,
    input  logic [2:0] cfg_index,
    input  logic [0:0] cfg_data
);
    import cpwe_pkg::*;

    localparam int DEPTH = NUM_CODES * CHAR_ROWS;
    localparam int AW    = $clog2(DEPTH);

    cfg_t       cfg_reg, cfg_next;
    logic       s1_valid_reg, s1_valid_next;
    logic [1:0] s1_cmd_reg, s1_cmd_next;
    logic [7:0] s1_code_reg, s1_code_next;
    logic [3:0] s1_row_reg, s1_row_next;
    logic [7:0] s1_bits_reg, s1_bits_next;
    logic       s2_done_reg, s2_done_next;
    logic       s2_ok_reg, s2_ok_next;
    logic       s2_read_reg, s2_read_next;

    logic          take;
    logic          s1_ok;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;

    // Commands are taken every cycle.
    assign busy = 1'b0;
    assign take = start && !busy;

    // Configuration register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_EIGHT_PIXEL: cfg_next.eight_pixel = cfg_data[0];
                CFG_GFX_LOW:     cfg_next.gfx_low     = cfg_data[0];
                CFG_GFX_HIGH:    cfg_next.gfx_high    = cfg_data[0];
                CFG_BLANK_UPPER: cfg_next.blank_upper = cfg_data[0];
                CFG_BLANK_LOWER: cfg_next.blank_lower = cfg_data[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    // Input stage: capture the command transfer.
    always_comb
    begin
        s1_valid_next = take;
        s1_cmd_next   = command;
        s1_code_next  = char_code;
        s1_row_next   = row_index;
        s1_bits_next  = pixel_bits;
    end

    // A command acts only on a known command code and a row inside the character.
    assign s1_ok = (s1_row_reg < 4'(CHAR_ROWS))
                   && ((s1_cmd_reg == CMD_LOAD) || (s1_cmd_reg == CMD_UPDATE)
                       || (s1_cmd_reg == CMD_READ));

    // Row address inside the pattern store.
    assign ram_addr = AW'(s1_code_reg) * AW'(CHAR_ROWS) + AW'(s1_row_reg);
    assign ram_we   = s1_valid_reg && s1_ok && (s1_cmd_reg != CMD_READ);

    cpwe_fmt #(
        .CHAR_ROWS (CHAR_ROWS)
    ) u_fmt (
        .cmd        (cmd_t'(s1_cmd_reg)),
        .char_code  (s1_code_reg),
        .row_index  (s1_row_reg),
        .pixel_bits (s1_bits_reg),
        .cfg        (cfg_reg),
        .wr_value   (ram_wdata)
    );

    cpwe_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Result stage: flags that travel alongside the RAM read.
    always_comb
    begin
        s2_done_next = s1_valid_reg;
        s2_ok_next   = s1_valid_reg && s1_ok;
        s2_read_next = s1_valid_reg && s1_ok && (s1_cmd_reg == CMD_READ);
    end

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg      <= '{eight_pixel: 1'b0, gfx_low: 1'b1, gfx_high: 1'b0,
                              blank_upper: 1'b0, blank_lower: 1'b0};
            s1_valid_reg <= 1'b0;
            s2_done_reg  <= 1'b0;
            s2_ok_reg    <= 1'b0;
            s2_read_reg  <= 1'b0;
        end
        else
        begin
            cfg_reg      <= cfg_next;
            s1_valid_reg <= s1_valid_next;
            s2_done_reg  <= s2_done_next;
            s2_ok_reg    <= s2_ok_next;
            s2_read_reg  <= s2_read_next;
        end
    end

    // Payload registers of the input stage.
    always_ff @(posedge clk)
    begin
        s1_cmd_reg  <= s1_cmd_next;
        s1_code_reg <= s1_code_next;
        s1_row_reg  <= s1_row_next;
        s1_bits_reg <= s1_bits_next;
    end

    // Result ports: rows only on a read that was carried out.
    assign done           = s2_done_reg;
    assign accepted       = s2_ok_reg;
    assign normal_row     = s2_read_reg ? ram_rdata : 8'h00;
    assign wide_left_row  = s2_read_reg ? widen_left(ram_rdata, cfg_reg.eight_pixel) : 8'h00;
    assign wide_right_row = s2_read_reg ? widen_right(ram_rdata, cfg_reg.eight_pixel) : 8'h00;

    // Every result follows a command transfer through the input and result registers.
    `CPWE_ASSERT_SAME(a_done_follows_cmd, done, $past(take, 2))
    // A command with a row out of range yields a rejected result.
    `CPWE_ASSERT_NEXT(a_bad_row_rejected, s1_valid_reg && (s1_row_reg >= 4'(CHAR_ROWS)),
        done && !accepted)
    // Row data appears only on an accepted result.
    `CPWE_ASSERT_SAME(a_rows_only_on_read, (normal_row != 8'h00) || (wide_left_row != 8'h00),
        done && accepted)
    // A read command never comes out as an accepted result without its read flag.
    `CPWE_ASSERT_NEXT(a_read_no_write, s1_valid_reg && (s1_cmd_reg == CMD_READ),
        !s2_ok_reg || s2_read_reg)

endmodule
